[sv/chts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package chts_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int WORD_W = 32;
   localparam int LINE_W = 2 * WORD_W;
   localparam int MUL_W = WORD_W + 1;
   localparam int PROD_W = 2 * MUL_W;
   localparam int VALUE_W = 64;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SELECT_MAX = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MONOTONIC = CSR_INDEX_W'(1);

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic select_max;
      logic monotonic;
   } cfg_type;

   typedef struct packed {
      logic                      operation;
      logic signed [WORD_W-1:0]  slope;
      logic signed [WORD_W-1:0]  intercept;
      logic signed [WORD_W-1:0]  query_x;
   } req_type;

   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] best_value;
      status_type                status;
   } result_type;

endpackage

`default_nettype wire

[sv/chts_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface chts_req_if;
   logic                                valid;
   logic                                ready;
   logic                                operation;
   logic signed [chts_pkg::WORD_W-1:0]  slope;
   logic signed [chts_pkg::WORD_W-1:0]  intercept;
   logic signed [chts_pkg::WORD_W-1:0]  query_x;

   modport source (output valid, operation, slope, intercept, query_x, input ready);
   modport sink (input valid, operation, slope, intercept, query_x, output ready);
endinterface

`default_nettype wire

[sv/chts_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface chts_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [chts_pkg::VALUE_W-1:0] best_value;
   logic [1:0]                          status;

   modport source (output valid, best_value, status, input ready);
   modport sink (input valid, best_value, status, output ready);
endinterface

`default_nettype wire

[sv/chts_csr_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface chts_csr_if;
   logic                                valid;
   logic                                ready;
   logic [chts_pkg::CSR_INDEX_W-1:0]    index;
   logic [chts_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[sv/chts_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module chts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/chts_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module chts_mul (
   input  wire logic                                clock,
   input  wire logic signed [chts_pkg::MUL_W-1:0]   op_a,
   input  wire logic signed [chts_pkg::MUL_W-1:0]   op_b,
   output logic      signed [chts_pkg::PROD_W-1:0]  product
);

   logic signed [chts_pkg::PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= op_a * op_b;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

[sv/chts_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module chts_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire chts_pkg::cfg_type      cfg,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire chts_pkg::req_type      req,
   output chts_pkg::result_type        result,
   input  wire logic                   res_ready
);

   localparam int AW = chts_pkg::ADDR_W;
   localparam int CW = chts_pkg::COUNT_W;
   localparam int WW = chts_pkg::WORD_W;
   localparam int MW = chts_pkg::MUL_W;
   localparam int PW = chts_pkg::PROD_W;
   localparam int VW = chts_pkg::VALUE_W;
   localparam int LW = chts_pkg::LINE_W;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ADD_CHECK,
      ST_ADD_RD1,
      ST_ADD_RD2,
      ST_ADD_MUL1,
      ST_ADD_MUL2,
      ST_ADD_CMP,
      ST_ADD_PUSH,
      ST_MONO_CHECK,
      ST_BS_CHECK,
      ST_PAIR_RD0,
      ST_PAIR_RD1,
      ST_PAIR_MR,
      ST_PAIR_AR,
      ST_PAIR_CMP,
      ST_FIN_RD,
      ST_FIN_MUL,
      ST_FIN_ADD,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;

   logic signed [WW-1:0] a_ff, a_in;
   logic signed [WW-1:0] b_ff, b_in;
   logic signed [WW-1:0] x_ff, x_in;

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] c_ff, c_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] lo1_ff, lo1_in;
   logic [AW-1:0] hi_ff, hi_in;

   logic signed [WW-1:0] o1_slope_ff, o1_slope_in;
   logic signed [WW-1:0] o1_icpt_ff, o1_icpt_in;
   logic signed [WW-1:0] o3_slope_ff, o3_slope_in;
   logic signed [WW-1:0] o3_icpt_ff, o3_icpt_in;

   logic signed [MW-1:0] dy1_ff, dy1_in;
   logic signed [MW-1:0] dx1_ff, dx1_in;
   logic signed [MW-1:0] dy2_ff, dy2_in;
   logic signed [MW-1:0] dx2_ff, dx2_in;

   logic signed [PW-1:0] prod1_ff, prod1_in;
   logic signed [WW-1:0] bl_ff, bl_in;
   logic signed [WW-1:0] br_ff, br_in;
   logic signed [VW-1:0] left_ff, left_in;
   logic signed [VW-1:0] right_ff, right_in;
   logic signed [VW-1:0] value_ff, value_in;
   chts_pkg::status_type status_ff, status_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [LW-1:0] wr_data;
   logic [AW-1:0] rd_addr;
   logic [LW-1:0] rd_data;

   logic signed [MW-1:0] mul_a;
   logic signed [MW-1:0] mul_b;
   logic signed [PW-1:0] product;

   logic signed [WW-1:0] rd_slope;
   logic signed [WW-1:0] rd_icpt;
   logic                 swap;
   logic                 move_on;
   logic [CW:0]          mid_sum;

   chts_ram #(
      .WIDTH (LW),
      .DEPTH (chts_pkg::CAPACITY)
   ) u_lines (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   chts_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   assign rd_slope = rd_data[LW-1:WW];
   assign rd_icpt  = rd_data[WW-1:0];

   // The outer lines are ordered so that the first has the larger slope.
   assign swap = (rd_slope < a_ff) || ((rd_slope == a_ff) && (rd_icpt < b_ff));

   assign move_on = cfg.select_max ? (left_ff <= right_ff) : (left_ff >= right_ff);

   assign mid_sum = (CW+1)'(hi_ff) + (CW+1)'(lo1_ff) - (CW+1)'(1);

   assign wr_addr = c_ff[AW-1:0];
   assign wr_data = {a_ff, b_ff};

   always_comb begin
      state_in    = state_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      x_in        = x_ff;
      count_in    = count_ff;
      head_in     = head_ff;
      c_in        = c_ff;
      idx_in      = idx_ff;
      lo1_in      = lo1_ff;
      hi_in       = hi_ff;
      o1_slope_in = o1_slope_ff;
      o1_icpt_in  = o1_icpt_ff;
      o3_slope_in = o3_slope_ff;
      o3_icpt_in  = o3_icpt_ff;
      dy1_in      = dy1_ff;
      dx1_in      = dx1_ff;
      dy2_in      = dy2_ff;
      dx2_in      = dx2_ff;
      prod1_in    = prod1_ff;
      bl_in       = bl_ff;
      br_in       = br_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      value_in    = value_ff;
      status_in   = status_ff;
      wr_en       = 1'b0;
      rd_addr     = '0;
      mul_a       = '0;
      mul_b       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               a_in      = req.slope;
               b_in      = req.intercept;
               x_in      = req.query_x;
               value_in  = '0;
               status_in = chts_pkg::STATUS_OK;
               if (req.operation == chts_pkg::OP_ADD) begin
                  c_in     = count_ff;
                  state_in = ST_ADD_CHECK;
               end else if (count_ff == '0) begin
                  status_in = chts_pkg::STATUS_EMPTY;
                  state_in  = ST_RESULT;
               end else if (cfg.monotonic) begin
                  if (CW'(head_ff) > count_ff - CW'(1)) begin
                     head_in = AW'(count_ff - CW'(1));
                  end
                  state_in = ST_MONO_CHECK;
               end else begin
                  lo1_in   = '0;
                  hi_in    = AW'(count_ff - CW'(1));
                  state_in = ST_BS_CHECK;
               end
            end
         end
         ST_ADD_CHECK: begin
            rd_addr = AW'(c_ff - CW'(2));
            if (c_ff >= CW'(2)) begin
               state_in = ST_ADD_RD1;
            end else begin
               state_in = ST_ADD_PUSH;
            end
         end
         ST_ADD_RD1: begin
            rd_addr = AW'(c_ff - CW'(1));
            if (swap) begin
               o1_slope_in = a_ff;
               o1_icpt_in  = b_ff;
               o3_slope_in = rd_slope;
               o3_icpt_in  = rd_icpt;
            end else begin
               o1_slope_in = rd_slope;
               o1_icpt_in  = rd_icpt;
               o3_slope_in = a_ff;
               o3_icpt_in  = b_ff;
            end
            state_in = ST_ADD_RD2;
         end
         ST_ADD_RD2: begin
            dy1_in   = {o3_icpt_ff[WW-1], o3_icpt_ff} - {rd_icpt[WW-1], rd_icpt};
            dx1_in   = {rd_slope[WW-1], rd_slope} - {o1_slope_ff[WW-1], o1_slope_ff};
            dy2_in   = {rd_icpt[WW-1], rd_icpt} - {o1_icpt_ff[WW-1], o1_icpt_ff};
            dx2_in   = {o3_slope_ff[WW-1], o3_slope_ff} - {rd_slope[WW-1], rd_slope};
            state_in = ST_ADD_MUL1;
         end
         ST_ADD_MUL1: begin
            mul_a    = dy1_ff;
            mul_b    = dx1_ff;
            state_in = ST_ADD_MUL2;
         end
         ST_ADD_MUL2: begin
            mul_a    = dy2_ff;
            mul_b    = dx2_ff;
            prod1_in = product;
            state_in = ST_ADD_CMP;
         end
         ST_ADD_CMP: begin
            if (prod1_ff >= product) begin
               c_in     = c_ff - CW'(1);
               state_in = ST_ADD_CHECK;
            end else begin
               state_in = ST_ADD_PUSH;
            end
         end
         ST_ADD_PUSH: begin
            if (c_ff >= CW'(chts_pkg::CAPACITY)) begin
               status_in = chts_pkg::STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = c_ff + CW'(1);
               if (CW'(head_ff) > c_ff) begin
                  head_in = c_ff[AW-1:0];
               end
            end
            state_in = ST_RESULT;
         end
         ST_MONO_CHECK: begin
            idx_in = head_ff;
            if (count_ff - CW'(head_ff) >= CW'(2)) begin
               state_in = ST_PAIR_RD0;
            end else begin
               state_in = ST_FIN_RD;
            end
         end
         ST_BS_CHECK: begin
            if (CW'(hi_ff) > lo1_ff) begin
               idx_in   = mid_sum[AW:1];
               state_in = ST_PAIR_RD0;
            end else begin
               idx_in   = hi_ff;
               state_in = ST_FIN_RD;
            end
         end
         ST_PAIR_RD0: begin
            rd_addr  = idx_ff;
            state_in = ST_PAIR_RD1;
         end
         ST_PAIR_RD1: begin
            rd_addr  = idx_ff + AW'(1);
            mul_a    = {rd_slope[WW-1], rd_slope};
            mul_b    = {x_ff[WW-1], x_ff};
            bl_in    = rd_icpt;
            state_in = ST_PAIR_MR;
         end
         ST_PAIR_MR: begin
            mul_a    = {rd_slope[WW-1], rd_slope};
            mul_b    = {x_ff[WW-1], x_ff};
            br_in    = rd_icpt;
            left_in  = product[VW-1:0] + {{(VW-WW){bl_ff[WW-1]}}, bl_ff};
            state_in = ST_PAIR_AR;
         end
         ST_PAIR_AR: begin
            right_in = product[VW-1:0] + {{(VW-WW){br_ff[WW-1]}}, br_ff};
            state_in = ST_PAIR_CMP;
         end
         ST_PAIR_CMP: begin
            if (cfg.monotonic) begin
               if (move_on) begin
                  head_in  = head_ff + AW'(1);
                  state_in = ST_MONO_CHECK;
               end else begin
                  idx_in   = head_ff;
                  state_in = ST_FIN_RD;
               end
            end else begin
               if (move_on) begin
                  lo1_in = CW'(idx_ff) + CW'(1);
               end else begin
                  hi_in = idx_ff;
               end
               state_in = ST_BS_CHECK;
            end
         end
         ST_FIN_RD: begin
            rd_addr  = idx_ff;
            state_in = ST_FIN_MUL;
         end
         ST_FIN_MUL: begin
            mul_a    = {rd_slope[WW-1], rd_slope};
            mul_b    = {x_ff[WW-1], x_ff};
            bl_in    = rd_icpt;
            state_in = ST_FIN_ADD;
         end
         ST_FIN_ADD: begin
            value_in = product[VW-1:0] + {{(VW-WW){bl_ff[WW-1]}}, bl_ff};
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         head_ff  <= head_in;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      x_ff        <= x_in;
      c_ff        <= c_in;
      idx_ff      <= idx_in;
      lo1_ff      <= lo1_in;
      hi_ff       <= hi_in;
      o1_slope_ff <= o1_slope_in;
      o1_icpt_ff  <= o1_icpt_in;
      o3_slope_ff <= o3_slope_in;
      o3_icpt_ff  <= o3_icpt_in;
      dy1_ff      <= dy1_in;
      dx1_ff      <= dx1_in;
      dy2_ff      <= dy2_in;
      dx2_ff      <= dx2_in;
      prod1_ff    <= prod1_in;
      bl_ff       <= bl_in;
      br_ff       <= br_in;
      left_ff     <= left_in;
      right_ff    <= right_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign result.valid      = (state_ff == ST_RESULT);
   assign result.best_value = value_ff;
   assign result.status     = status_ff;

endmodule

`default_nettype wire

[sv/convex_hull_trick_line_store.sv]
`timescale 1ns / 1ps
`default_nettype none

// Convex hull trick line store.
// Requests arrive as beats on req_chan: an add pushes the line slope*x + intercept
// (lines must come in slope order), a query returns the minimum or maximum of all
// stored lines at query_x. Every request yields exactly one beat on rsp_chan with
// best_value and status (ok, store full and line dropped, or query on empty store).
// csr_chan writes select_max (index 0) and monotonic_queries (index 1); it is always
// ready and should be used only while no request is in flight.
// One request is worked at a time; req_chan is not ready from acceptance until the
// result has moved into the output register. An add runs redundancy tests on the
// lines below the new one, and a query either binary-searches the hull or, in
// monotonic mode, steps the head pointer forward. A query on an empty store goes
// straight to the result. The work is serialised by the single read port of the
// line memory and the one shared 33 x 33 multiplier.
// A result held in the output register does not block the next request; only the
// hand-over of the following result waits while the receiver stalls.
// Reset empties the store, zeroes the head pointer and clears both registers; it
// needs no clearing pass over the line memory.

module convex_hull_trick_line_store (
   input  wire logic clock,
   input  wire logic reset,
   chts_req_if.sink   req_chan,
   chts_rsp_if.source rsp_chan,
   chts_csr_if.sink   csr_chan
);

   chts_pkg::cfg_type    cfg_ff, cfg_in;
   chts_pkg::req_type    req;
   chts_pkg::result_type seq_result;
   logic                 seq_ready;
   logic                 res_ready;
   logic                 load;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [chts_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]                          rsp_status_ff, rsp_status_in;

   assign req.operation = req_chan.operation;
   assign req.slope     = req_chan.slope;
   assign req.intercept = req_chan.intercept;
   assign req.query_x   = req_chan.query_x;
   assign req_chan.ready = seq_ready;

   chts_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_chan.valid),
      .req_ready (seq_ready),
      .req       (req),
      .result    (seq_result),
      .res_ready (res_ready)
   );

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            chts_pkg::CSR_SELECT_MAX: cfg_in.select_max = csr_chan.data[0];
            chts_pkg::CSR_MONOTONIC:  cfg_in.monotonic  = csr_chan.data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   assign res_ready = !rsp_valid_ff || rsp_chan.ready;
   assign load      = seq_result.valid && res_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = seq_result.best_value;
         rsp_status_in = seq_result.status;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.best_value = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request accepted while the sequencer stays ready");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_chan.valid && rsp_chan.best_value == $past(seq_result.best_value))
      else $error("result not moved into the output register");

   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != chts_pkg::STATUS_OK |-> rsp_chan.best_value == 0)
      else $error("nonzero value with an error status");

endmodule

`default_nettype wire
